@@ hw/rtl/sftd_pkg.sv @@
// shared types, constants and a helper function of the fixed-point to double converter
package sftd_pkg;

    localparam int MANT_W = 53;
    localparam int PROD_W = 2 * MANT_W;
    localparam int LO_W   = 27;
    localparam int HI_W   = MANT_W - LO_W;

    typedef logic signed [12:0] exp_t;
    typedef logic [MANT_W-1:0]  mant_t;
    typedef logic [PROD_W-1:0]  prod_t;

    localparam exp_t  EXP_BIAS = 13'sd1023;
    localparam exp_t  EXP_MIN  = -13'sd1022;
    localparam exp_t  EXP_MAX  = 13'sd1023;
    localparam mant_t MANT_ONE = {1'b1, 52'b0};

    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [63:0] QNAN_BITS    = 64'h7FF8000000000000;

    // leading zero count over 64 bits, binary search in six halving steps
    function automatic logic [5:0] lzc64(input logic [63:0] x);
        logic [63:0] v;
        logic [5:0]  n;
        v = x;
        n = 6'd0;
        if (v[63:32] == 32'd0)
        begin
            n[5] = 1'b1;
            v    = v << 32;
        end
        if (v[63:48] == 16'd0)
        begin
            n[4] = 1'b1;
            v    = v << 16;
        end
        if (v[63:56] == 8'd0)
        begin
            n[3] = 1'b1;
            v    = v << 8;
        end
        if (v[63:60] == 4'd0)
        begin
            n[2] = 1'b1;
            v    = v << 4;
        end
        if (v[63:62] == 2'd0)
        begin
            n[1] = 1'b1;
            v    = v << 2;
        end
        if (v[63] == 1'b0)
        begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/sftd_mul.sv @@
// two-stage 53 by 53 bit mantissa multiplier built from four partial products
module sftd_mul (
    input  logic            clk,
    input  sftd_pkg::mant_t a,
    input  sftd_pkg::mant_t b,
    output sftd_pkg::prod_t p
);

    logic [2*sftd_pkg::LO_W-1:0]             pp_ll_reg, pp_ll_next;
    logic [sftd_pkg::LO_W+sftd_pkg::HI_W-1:0] pp_lh_reg, pp_lh_next;
    logic [sftd_pkg::LO_W+sftd_pkg::HI_W-1:0] pp_hl_reg, pp_hl_next;
    logic [2*sftd_pkg::HI_W-1:0]             pp_hh_reg, pp_hh_next;
    sftd_pkg::prod_t                         p_reg, p_next;

    // first stage: partial products, each at most 27 by 27 bits
    always_comb
    begin
        pp_ll_next = a[sftd_pkg::LO_W-1:0] * b[sftd_pkg::LO_W-1:0];
        pp_lh_next = a[sftd_pkg::LO_W-1:0] * b[sftd_pkg::MANT_W-1:sftd_pkg::LO_W];
        pp_hl_next = a[sftd_pkg::MANT_W-1:sftd_pkg::LO_W] * b[sftd_pkg::LO_W-1:0];
        pp_hh_next = a[sftd_pkg::MANT_W-1:sftd_pkg::LO_W] * b[sftd_pkg::MANT_W-1:sftd_pkg::LO_W];
    end

    // second stage: weighted sum
    always_comb
    begin
        p_next = (sftd_pkg::prod_t'(pp_hh_reg) << (2 * sftd_pkg::LO_W))
               + ((sftd_pkg::prod_t'(pp_lh_reg) + sftd_pkg::prod_t'(pp_hl_reg))
                  << sftd_pkg::LO_W)
               + sftd_pkg::prod_t'(pp_ll_reg);
    end

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= pp_ll_next;
        pp_lh_reg <= pp_lh_next;
        pp_hl_reg <= pp_hl_next;
        pp_hh_reg <= pp_hh_next;
        p_reg     <= p_next;
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/scaled_fixed_to_double.sv @@
// top level of the pipelined scaled fixed-point to double converter
//
// usage
//   a request is taken at a rising edge with start high and busy low; busy is
//   never raised, so one request may be issued in every cycle
//   each request carries a raw word, the field's top bit index, its bit count,
//   a signedness flag and a double scale pattern
//   the result (value_bits, rejected) is shown for exactly one cycle with done
//   high; the receiver cannot stall it
//   throughput is one request per cycle: eleven register stages, each holding
//   one shift, count, add or half of the mantissa product
//   the 53 by 53 bit mantissa product takes two of those stages (four partial
//   products, then their sum)
//   rejected requests (top bit or count out of range, negative scale) give +0.0
//   reset clears only the valid bits; requests in flight at reset are dropped
//   and no done strobe follows them
module scaled_fixed_to_double #(
    parameter int WORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] raw_word,
    input  logic [5:0]  top_bit,
    input  logic [6:0]  bit_count,
    input  logic        is_signed,
    input  logic [63:0] scale_bits,
    output logic        done,
    output logic [63:0] value_bits,
    output logic        rejected
);

    localparam int         LAT     = 11;
    localparam logic [5:0] TOP_MAX = 6'(WORD_BITS - 1);
    localparam logic [6:0] CNT_MAX = 7'(WORD_BITS);

    // special results, worked out once both operands are known
    typedef struct packed {
        logic sign;
        logic zero;
        logic inf;
        logic nan;
        logic rej;
    } flag_t;

    typedef struct packed {
        logic [63:0] mag64;
        logic        neg;
        logic        sgn;
        logic [6:0]  count;
        logic [10:0] sexp;
        logic [51:0] sfrac;
        logic        use_s;
        logic        inf_s;
        logic        rej;
    } st1_t;

    typedef struct packed {
        logic [63:0] mag64;
        logic [5:0]  lz;
        logic        vzero;
        logic        neg;
        logic        sgn;
        logic [6:0]  count;
        logic [10:0] sexp;
        logic [51:0] sfrac;
        logic [5:0]  k;
        logic        use_s;
        logic        inf_s;
        logic        rej;
    } st2_t;

    typedef struct packed {
        logic [63:0]     norm;
        sftd_pkg::exp_t  p;
        logic            vzero;
        logic            neg;
        logic [5:0]      n;
        logic [6:0]      count;
        sftd_pkg::mant_t ms;
        sftd_pkg::exp_t  es;
        logic            use_s;
        logic            inf_s;
        logic            rej;
    } st3_t;

    typedef struct packed {
        sftd_pkg::mant_t mv;
        sftd_pkg::exp_t  ev;
        logic            vzero;
        logic            neg;
        sftd_pkg::mant_t sf;
        sftd_pkg::exp_t  esx;
        logic            ssub;
        logic            inf_s;
        logic            rej;
    } st4_t;

    typedef struct packed {
        st4_t       b;
        logic [5:0] k2;
    } st5_t;

    typedef struct packed {
        sftd_pkg::mant_t ma;
        sftd_pkg::mant_t mb;
        sftd_pkg::exp_t  e;
        flag_t           f;
    } st6_t;

    typedef struct packed {
        sftd_pkg::exp_t e;
        flag_t          f;
    } side_t;

    typedef struct packed {
        sftd_pkg::prod_t q;
        sftd_pkg::exp_t  ep;
        logic [5:0]      sh2;
        flag_t           f;
    } st9_t;

    typedef struct packed {
        sftd_pkg::mant_t m;
        logic            g;
        logic            st;
        sftd_pkg::exp_t  ep;
        logic            sub2;
        flag_t           f;
    } st10_t;

    logic [LAT-1:0] vld_reg, vld_next;
    st1_t  s1_reg,  s1_next;
    st2_t  s2_reg,  s2_next;
    st3_t  s3_reg,  s3_next;
    st4_t  s4_reg,  s4_next;
    st5_t  s5_reg,  s5_next;
    st6_t  s6_reg,  s6_next;
    side_t s7_reg,  s7_next;
    side_t s8_reg,  s8_next;
    st9_t  s9_reg,  s9_next;
    st10_t s10_reg, s10_next;
    logic [63:0] value_reg, value_next;
    logic        rej_reg,   rej_next;

    sftd_pkg::prod_t prod;

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    // stage 1: range checks, scale class, alignment and magnitude
    always_comb
    begin
        logic [5:0]           sh_al;
        logic [WORD_BITS-1:0] w;
        logic [WORD_BITS-1:0] mag;
        logic                 neg;
        logic                 s_zero;
        logic                 s_nan;
        logic                 s_negv;
        sh_al  = TOP_MAX - top_bit;
        w      = raw_word[WORD_BITS-1:0] << sh_al;
        neg    = is_signed & w[WORD_BITS-1];
        mag    = neg ? WORD_BITS'(~w + 1'b1) : w;
        s_zero = (scale_bits[62:52] == 11'd0) && (scale_bits[51:0] == 52'd0);
        s_nan  = (scale_bits[62:52] == sftd_pkg::EXP_ALL_ONES) && (scale_bits[51:0] != 52'd0);
        s_negv = scale_bits[63] & ~s_zero & ~s_nan;
        s1_next.mag64 = 64'(mag) << (64 - WORD_BITS);
        s1_next.neg   = neg;
        s1_next.sgn   = is_signed;
        s1_next.count = bit_count;
        s1_next.sexp  = scale_bits[62:52];
        s1_next.sfrac = scale_bits[51:0];
        s1_next.use_s = ~scale_bits[63] & ~s_zero & ~s_nan;
        s1_next.inf_s = ~scale_bits[63] & (scale_bits[62:52] == sftd_pkg::EXP_ALL_ONES)
                      & (scale_bits[51:0] == 52'd0);
        s1_next.rej   = (top_bit == 6'd0) || (top_bit > TOP_MAX) || (bit_count == 7'd0)
                      || (bit_count > CNT_MAX) || s_negv;
    end

    // stage 2: leading zero counts of the magnitude and of a subnormal scale
    always_comb
    begin
        s2_next.mag64 = s1_reg.mag64;
        s2_next.lz    = sftd_pkg::lzc64(s1_reg.mag64);
        s2_next.vzero = (s1_reg.mag64 == 64'd0);
        s2_next.neg   = s1_reg.neg;
        s2_next.sgn   = s1_reg.sgn;
        s2_next.count = s1_reg.count;
        s2_next.sexp  = s1_reg.sexp;
        s2_next.sfrac = s1_reg.sfrac;
        s2_next.k     = sftd_pkg::lzc64({1'b0, s1_reg.sfrac, 11'b0});
        s2_next.use_s = s1_reg.use_s;
        s2_next.inf_s = s1_reg.inf_s;
        s2_next.rej   = s1_reg.rej;
    end

    // stage 3: normalise magnitude, unpack scale into mantissa and exponent
    always_comb
    begin
        s3_next.norm  = s2_reg.mag64 << s2_reg.lz;
        s3_next.p     = sftd_pkg::exp_t'(WORD_BITS - 1) - sftd_pkg::exp_t'({7'b0, s2_reg.lz});
        s3_next.vzero = s2_reg.vzero;
        s3_next.neg   = s2_reg.neg;
        s3_next.n     = TOP_MAX - {5'b0, s2_reg.sgn};
        s3_next.count = s2_reg.count;
        if (s2_reg.sexp == 11'd0)
        begin
            s3_next.ms = sftd_pkg::mant_t'({1'b0, s2_reg.sfrac} << s2_reg.k);
            s3_next.es = sftd_pkg::EXP_MIN - sftd_pkg::exp_t'({7'b0, s2_reg.k});
        end
        else
        begin
            s3_next.ms = {1'b1, s2_reg.sfrac};
            s3_next.es = sftd_pkg::exp_t'({2'b0, s2_reg.sexp}) - sftd_pkg::EXP_BIAS;
        end
        s3_next.use_s = s2_reg.use_s;
        s3_next.inf_s = s2_reg.inf_s;
        s3_next.rej   = s2_reg.rej;
    end

    // stage 4: round the word to 53 bits; divide scale by 2^n, rounding if subnormal
    always_comb
    begin
        logic [53:0]     r;
        logic            inc;
        sftd_pkg::exp_t  es_n;
        sftd_pkg::exp_t  shx;
        logic [5:0]      sh;
        logic [116:0]    ext;
        sftd_pkg::mant_t sft;
        inc  = s3_reg.norm[10] & ((|s3_reg.norm[9:0]) | s3_reg.norm[11]);
        r    = {1'b0, s3_reg.norm[63:11]} + {53'b0, inc};
        es_n = s3_reg.es - sftd_pkg::exp_t'({7'b0, s3_reg.n});
        shx  = sftd_pkg::EXP_MIN - es_n;
        sh   = (shx > 13'sd63) ? 6'd63 : shx[5:0];
        ext  = {s3_reg.ms, 64'b0} >> sh;
        sft  = ext[116:64];
        s4_next.mv    = r[53] ? r[53:1] : r[52:0];
        s4_next.ev    = s3_reg.p + sftd_pkg::exp_t'({12'b0, r[53]});
        s4_next.vzero = s3_reg.vzero;
        s4_next.neg   = s3_reg.neg;
        s4_next.inf_s = s3_reg.inf_s;
        s4_next.rej   = s3_reg.rej;
        if (!s3_reg.use_s)
        begin
            // default weighting: the aligned bit at word_bits minus count weighs one
            s4_next.sf   = sftd_pkg::MANT_ONE;
            s4_next.esx  = sftd_pkg::exp_t'({6'b0, s3_reg.count}) - sftd_pkg::exp_t'(WORD_BITS);
            s4_next.ssub = 1'b0;
        end
        else if (es_n < sftd_pkg::EXP_MIN)
        begin
            s4_next.sf   = sft + sftd_pkg::mant_t'(ext[63] & ((|ext[62:0]) | sft[0]));
            s4_next.esx  = es_n;
            s4_next.ssub = 1'b1;
        end
        else
        begin
            s4_next.sf   = s3_reg.ms;
            s4_next.esx  = es_n;
            s4_next.ssub = 1'b0;
        end
    end

    // stage 5: leading zeros of a subnormal divided scale
    always_comb
    begin
        s5_next.b  = s4_reg;
        s5_next.k2 = sftd_pkg::lzc64({s4_reg.sf, 11'b0});
    end

    // stage 6: renormalise divided scale, sum exponents, settle special cases
    always_comb
    begin
        logic           szero;
        sftd_pkg::exp_t es2;
        szero = s5_reg.b.ssub && (s5_reg.b.sf == '0);
        if (s5_reg.b.ssub)
        begin
            s6_next.mb = s5_reg.b.sf << s5_reg.k2;
            es2        = sftd_pkg::EXP_MIN - sftd_pkg::exp_t'({7'b0, s5_reg.k2});
        end
        else
        begin
            s6_next.mb = s5_reg.b.sf;
            es2        = s5_reg.b.esx;
        end
        s6_next.ma     = s5_reg.b.mv;
        s6_next.e      = s5_reg.b.ev + es2;
        s6_next.f.sign = s5_reg.b.neg;
        s6_next.f.zero = s5_reg.b.vzero | szero;
        s6_next.f.inf  = s5_reg.b.inf_s & ~s5_reg.b.vzero;
        s6_next.f.nan  = s5_reg.b.inf_s & s5_reg.b.vzero;
        s6_next.f.rej  = s5_reg.b.rej;
    end

    sftd_mul u_mul (
        .clk (clk),
        .a   (s6_reg.ma),
        .b   (s6_reg.mb),
        .p   (prod)
    );

    // exponent and flags ride alongside the two multiplier stages
    always_comb
    begin
        s7_next.e = s6_reg.e;
        s7_next.f = s6_reg.f;
        s8_next   = s7_reg;
    end

    // stage 9: put the product's top bit at 105, work out any subnormal shift
    always_comb
    begin
        sftd_pkg::exp_t ep;
        sftd_pkg::exp_t shx;
        ep  = s8_reg.e + sftd_pkg::exp_t'({12'b0, prod[sftd_pkg::PROD_W-1]});
        shx = sftd_pkg::EXP_MIN - ep;
        s9_next.q   = prod[sftd_pkg::PROD_W-1] ? prod : (prod << 1);
        s9_next.ep  = ep;
        s9_next.sh2 = (ep >= sftd_pkg::EXP_MIN) ? 6'd0 :
                      ((shx > 13'sd63) ? 6'd63 : shx[5:0]);
        s9_next.f   = s8_reg.f;
    end

    // stage 10: subnormal shift with sticky, split into mantissa, guard and sticky
    always_comb
    begin
        logic [169:0]    ext;
        sftd_pkg::prod_t t;
        ext = {s9_reg.q, 64'b0} >> s9_reg.sh2;
        t   = ext[169:64];
        s10_next.m    = t[105:53];
        s10_next.g    = t[52];
        s10_next.st   = (|t[51:0]) | (|ext[63:0]);
        s10_next.ep   = s9_reg.ep;
        s10_next.sub2 = (s9_reg.sh2 != 6'd0);
        s10_next.f    = s9_reg.f;
    end

    // stage 11: round to nearest even, pack, apply special cases
    always_comb
    begin
        logic [53:0]    r;
        logic           inc;
        sftd_pkg::exp_t e;
        logic [51:0]    frac;
        logic [10:0]    efld;
        logic           ovf;
        inc = s10_reg.g & (s10_reg.st | s10_reg.m[0]);
        r   = {1'b0, s10_reg.m} + {53'b0, inc};
        e   = s10_reg.ep + sftd_pkg::exp_t'({12'b0, r[53]});
        ovf = 1'b0;
        if (s10_reg.sub2)
        begin
            efld = {10'b0, r[52]};
            frac = r[51:0];
        end
        else
        begin
            ovf  = (e > sftd_pkg::EXP_MAX);
            efld = 11'(e + sftd_pkg::EXP_BIAS);
            frac = r[53] ? r[52:1] : r[51:0];
        end
        rej_next = s10_reg.f.rej;
        if (s10_reg.f.rej)
        begin
            value_next = 64'd0;
        end
        else if (s10_reg.f.nan)
        begin
            value_next = sftd_pkg::QNAN_BITS;
        end
        else if (s10_reg.f.inf || (!s10_reg.f.zero && ovf))
        begin
            value_next = {s10_reg.f.sign, sftd_pkg::EXP_ALL_ONES, 52'b0};
        end
        else if (s10_reg.f.zero)
        begin
            value_next = {s10_reg.f.sign, 63'b0};
        end
        else
        begin
            value_next = {s10_reg.f.sign, efld, frac};
        end
    end

    // only the valid bits are reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        s3_reg    <= s3_next;
        s4_reg    <= s4_next;
        s5_reg    <= s5_next;
        s6_reg    <= s6_next;
        s7_reg    <= s7_next;
        s8_reg    <= s8_next;
        s9_reg    <= s9_next;
        s10_reg   <= s10_next;
        value_reg <= value_next;
        rej_reg   <= rej_next;
    end

    assign done       = vld_reg[LAT-1];
    assign value_bits = value_reg;
    assign rejected   = rej_reg;

    // every request is followed by its result strobe on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing after request");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a request");

    // a rejected request returns +0.0
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rejected) |-> (value_bits == 64'd0))
        else $error("rejected request with nonzero value");

    // any nan leaves as the canonical quiet nan
    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (value_bits[62:52] == sftd_pkg::EXP_ALL_ONES))
        |-> ((value_bits[51:0] == 52'd0) || (value_bits == sftd_pkg::QNAN_BITS)))
        else $error("non-canonical nan result");

endmodule

@@ tb/scaled_fixed_to_double_tb.sv @@
// self-checking testbench of the scaled fixed-point to double converter
module scaled_fixed_to_double_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1750;
    localparam int TAIL_ITEMS = 200;     // no idling over the last requests
    localparam int DRAIN_CYCLES = 30;    // pipeline is 11 deep, allow margin

    // one pending request as the driver sees it
    typedef struct {
        logic [63:0] raw;
        logic [5:0]  top;
        logic [6:0]  count;
        logic        sgn;
        logic [63:0] scale;
        bit          hold;     // wait for every result before issuing
        bit          no_gap;   // no idle bursts after this request
    } conv_req_t;

    typedef struct {
        logic [63:0] value;
        logic        rej;
    } conv_res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] raw_word;
    logic [5:0]  top_bit;
    logic [6:0]  bit_count;
    logic        is_signed;
    logic [63:0] scale_bits;
    logic        done;
    logic [63:0] value_bits;
    logic        rejected;

    conv_req_t pending_reqs[$];
    conv_res_t expected_results[$];
    int        fail_count = 0;
    int        idle_left  = 0;

    scaled_fixed_to_double #(.WORD_BITS(64)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .raw_word   (raw_word),
        .top_bit    (top_bit),
        .bit_count  (bit_count),
        .is_signed  (is_signed),
        .scale_bits (scale_bits),
        .done       (done),
        .value_bits (value_bits),
        .rejected   (rejected)
    );

    // free-running clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // power of two as a double pattern, k in 0..63
    function automatic real two_to(input int k);
        logic [10:0] e;
        e = 11'(1023 + k);
        return $bitstoreal({1'b0, e, 52'b0});
    endfunction

    // unsigned 64-bit integer to double, round to nearest with ties to even
    function automatic logic [63:0] u64_to_double(input logic [63:0] x, input logic neg);
        logic [63:0] m;
        logic [53:0] mant;
        logic [10:0] e;
        int          lz;
        if (x == 64'd0)
            return 64'd0;
        lz = 0;
        while (!x[63 - lz])
            lz++;
        m    = x << lz;
        e    = 11'(1023 + 63 - lz);
        mant = {1'b0, m[63:11]};
        // guard bit set and either sticky bits or an odd lsb: round up
        if (m[10] && ((|m[9:0]) || mant[0]))
            mant = mant + 54'd1;
        if (mant[53])
        begin
            mant = mant >> 1;
            e    = e + 11'd1;
        end
        return {neg, e, mant[51:0]};
    endfunction

    // expected result of one conversion request
    function automatic conv_res_t convert_request(input conv_req_t r);
        conv_res_t   res;
        logic [63:0] word;
        logic [63:0] mag;
        logic        neg;
        logic        s_nan;
        logic        s_zero;
        real         val;
        real         scale;
        logic [63:0] out;
        int          n;
        s_nan  = (r.scale[62:52] == sftd_pkg::EXP_ALL_ONES) && (r.scale[51:0] != 52'd0);
        s_zero = (r.scale[62:0] == 63'd0);
        res.value = 64'd0;
        res.rej   = 1'b1;
        // out-of-range top bit or count, or a scale below zero, is rejected
        if (r.top < 6'd1 || r.count < 7'd1 || r.count > 7'd64 ||
            (r.scale[63] && !s_nan && !s_zero))
            return res;
        res.rej = 1'b0;
        word = r.raw << (63 - r.top);
        n    = 63;
        neg  = 1'b0;
        mag  = word;
        if (r.sgn)
        begin
            n = 62;
            if (word[63])
            begin
                neg = 1'b1;
                mag = ~word + 64'd1;
            end
        end
        val = $bitstoreal(u64_to_double(mag, neg));
        // positive scale weighs the top magnitude bit, otherwise default weighting
        if (!r.scale[63] && !s_nan && !s_zero)
        begin
            scale = $bitstoreal(r.scale);
            val   = val * (scale / two_to(n));
        end
        else
            val = val / two_to(64 - int'(r.count));
        out = $realtobits(val);
        if (out[62:52] == sftd_pkg::EXP_ALL_ONES && out[51:0] != 52'd0)
            out = sftd_pkg::QNAN_BITS;
        res.value = out;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // scale pattern drawn from the interesting classes
    function automatic logic [63:0] rand_scale();
        case ($urandom_range(0, 11))
            0:       return 64'h0000000000000000;
            1:       return 64'h8000000000000000;
            2:       return 64'h7FF0000000000000;
            3:       return 64'hFFF0000000000000;
            4:       return {1'b0, 11'h7FF, 1'b1, 51'($urandom)};
            5:       return {1'b1, 11'($urandom_range(900, 1150)), 52'(rand64())};
            6:       return rand64();
            7:       return {1'b0, 11'($urandom_range(0, 3)), 52'(rand64())};
            default: return {1'b0, 11'($urandom_range(900, 1150)), 52'(rand64())};
        endcase
    endfunction

    function automatic conv_req_t rand_request(input bit quiet);
        conv_req_t r;
        int        w;
        w       = $urandom_range(1, 64);
        r.raw   = rand64() >> (64 - w);
        if ($urandom_range(0, 3) == 0)
            r.raw = rand64();
        if ($urandom_range(0, 15) == 0)
            r.raw = ($urandom_range(0, 1) != 0) ? 64'd0 : 64'h8000000000000000;
        r.top   = ($urandom_range(0, 19) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
        r.count = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(0, 127)) :
                                                 7'($urandom_range(1, 64));
        r.sgn   = 1'($urandom);
        r.scale = rand_scale();
        r.hold  = 1'b0;
        r.no_gap = quiet;
        return r;
    endfunction

    function automatic conv_req_t mk(input logic [63:0] raw, input logic [5:0] top,
                                      input logic [6:0] count, input logic sgn,
                                      input logic [63:0] scale);
        conv_req_t r;
        r.raw = raw;
        r.top = top;
        r.count = count;
        r.sgn = sgn;
        r.scale = scale;
        r.hold = 1'b0;
        r.no_gap = 1'b0;
        return r;
    endfunction

    // driver: a request is taken at an edge with start high and busy low
    always @(posedge clk or negedge rst_n)
    begin
        conv_req_t nxt;
        bit        issue;
        if (!rst_n)
        begin
            start      <= 1'b0;
            raw_word   <= 64'd0;
            top_bit    <= 6'd0;
            bit_count  <= 7'd0;
            is_signed  <= 1'b0;
            scale_bits <= 64'd0;
            idle_left  <= 0;
        end
        else
        begin
            issue = 1'b0;
            if (start && !busy)
            begin
                nxt.raw   = raw_word;
                nxt.top   = top_bit;
                nxt.count = bit_count;
                nxt.sgn   = is_signed;
                nxt.scale = scale_bits;
                expected_results.push_back(convert_request(nxt));
            end
            if (start && busy)
                issue = 1'b0;  // keep holding the current request
            else if (idle_left > 0)
                idle_left <= idle_left - 1;
            else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].hold &&
                       (expected_results.size() > 0 || (start && !busy))))
            begin
                nxt = pending_reqs.pop_front();
                issue = 1'b1;
                raw_word   <= nxt.raw;
                top_bit    <= nxt.top;
                bit_count  <= nxt.count;
                is_signed  <= nxt.sgn;
                scale_bits <= nxt.scale;
                if (!nxt.no_gap && $urandom_range(0, 7) == 0)
                    idle_left <= $urandom_range(1, 19);
            end
            if (!(start && busy))
                start <= issue;
        end
    end

    // monitor: each done strobe is checked against the oldest expectation
    always @(posedge clk)
    begin
        conv_res_t exp_r;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: value_bits %h", value_bits);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (value_bits !== exp_r.value)
                begin
                    $error("value_bits expected %h actual %h", exp_r.value, value_bits);
                    fail_count++;
                end
                if (rejected !== exp_r.rej)
                begin
                    $error("rejected expected %b actual %b", exp_r.rej, rejected);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        conv_req_t r;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and the special cases
        pending_reqs.push_back(mk(64'hFFFFFFFFFFFFFFFF, 6'd63, 7'd64, 1'b0, 64'd0));
        pending_reqs.push_back(mk(64'hFFFFFFFFFFFFFFFF, 6'd63, 7'd64, 1'b1, 64'd0));
        pending_reqs.push_back(mk(64'h8000000000000000, 6'd63, 7'd1, 1'b1, 64'd0));
        pending_reqs.push_back(mk(64'h0000000000000003, 6'd1, 7'd2, 1'b1, 64'd0));
        pending_reqs.push_back(mk(64'h0000000000000002, 6'd1, 7'd2, 1'b0, 64'd0));
        // invalid top bit, counts out of range
        pending_reqs.push_back(mk(64'h1234, 6'd0, 7'd16, 1'b0, 64'd0));
        pending_reqs.push_back(mk(64'h1234, 6'd15, 7'd0, 1'b0, 64'd0));
        pending_reqs.push_back(mk(64'h1234, 6'd15, 7'd65, 1'b0, 64'd0));
        pending_reqs.push_back(mk(64'h1234, 6'd15, 7'd127, 1'b1, 64'd0));
        // negative scale and negative infinity are rejected
        pending_reqs.push_back(mk(64'h1234, 6'd15, 7'd16, 1'b0, 64'hBFF0000000000000));
        pending_reqs.push_back(mk(64'h1234, 6'd15, 7'd16, 1'b0, 64'hFFF0000000000000));
        // negative zero and nan pick the default weighting
        pending_reqs.push_back(mk(64'h8001, 6'd15, 7'd16, 1'b1, 64'h8000000000000000));
        pending_reqs.push_back(mk(64'h8001, 6'd15, 7'd16, 1'b1, 64'h7FF8000000000001));
        pending_reqs.push_back(mk(64'h8001, 6'd15, 7'd16, 1'b1, 64'hFFFFFFFFFFFFFFFF));
        // positive infinity: nonzero word gives infinity, zero word gives nan
        pending_reqs.push_back(mk(64'h0005, 6'd15, 7'd16, 1'b0, 64'h7FF0000000000000));
        pending_reqs.push_back(mk(64'h0000, 6'd15, 7'd16, 1'b0, 64'h7FF0000000000000));
        pending_reqs.push_back(mk(64'h8000, 6'd15, 7'd16, 1'b1, 64'h7FF0000000000000));
        // positive scales, large and tiny
        pending_reqs.push_back(mk(64'h7FFF, 6'd15, 7'd16, 1'b1, 64'h4059000000000000));
        pending_reqs.push_back(mk(64'hFFFF, 6'd15, 7'd16, 1'b0, 64'h0000000000000001));
        pending_reqs.push_back(mk(64'hFFFFFFFFFFFFFFFF, 6'd63, 7'd64, 1'b0,
                                  64'h7FEFFFFFFFFFFFFF));
        // bits above the top bit are dropped; rounding ties
        pending_reqs.push_back(mk(64'hFFFF00000000F0F0, 6'd20, 7'd21, 1'b0, 64'd0));
        pending_reqs.push_back(mk(64'hFFFFFFFFFFFFFC00, 6'd63, 7'd64, 1'b0, 64'd0));
        pending_reqs.push_back(mk(64'hFFFFFFFFFFFFF400, 6'd63, 7'd64, 1'b0, 64'd0));

        // random part, with one pause until every result is in
        for (int i = 0; i < N_RANDOM; i++)
        begin
            r = rand_request(i >= N_RANDOM - TAIL_ITEMS);
            if (i == N_RANDOM / 2)
                r.hold = 1'b1;
            pending_reqs.push_back(r);
        end

        wait (pending_reqs.size() == 0);
        @(posedge clk);
        while (start)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/sftd_pkg.sv
hw/rtl/sftd_mul.sv
hw/rtl/scaled_fixed_to_double.sv
tb/scaled_fixed_to_double_tb.sv
